@@ rtl/per_key_cooldown_limiter_core_macros.svh @@
// Assertion macros used by the cooldown limiter top level.
`ifndef PER_KEY_COOLDOWN_LIMITER_CORE_MACROS_SVH
`define PER_KEY_COOLDOWN_LIMITER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PKCL_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cooldown limiter check failed");
`define PKCL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cooldown limiter check failed");
`else
`define PKCL_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define PKCL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/pkcl_pkg.sv @@
// Types, constants and state codes of the per-key cooldown limiter.
package pkcl_pkg;

  // Table depth; a power of two, since the eviction slot is now_ms modulo the depth.
  localparam int ENTRIES = 16;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [31:0] COOLDOWN_RESET = 32'd1000;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    ACT_HIT_OK      = 3'd0,
    ACT_HIT_LIMITED = 3'd1,
    ACT_FILLED      = 3'd2,
    ACT_EVICTED     = 3'd3,
    ACT_INVALID     = 3'd4
  } action_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic       limited;
    logic [3:0] slot;
    logic [2:0] action;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

endpackage

@@ rtl/per_key_cooldown_limiter_core.sv @@
// Top level of the per-key cooldown limiter.
// Each request item passes a lookup and an update state: the lookup state compares its key
// against all table entries and registers the first match and first free entry, then the
// update state checks the cooldown, writes the table unless the item is limited or invalid,
// and loads the result into the output register. A new item is accepted in the update state,
// so the block takes the next item while finishing the last one; a result left waiting holds
// the next item in its update state. The table resets to all free in the reset cycle itself.
// The cooldown register may be written at any idle time and is always ready.
`include "per_key_cooldown_limiter_core_macros.svh"
module per_key_cooldown_limiter_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pkcl_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pkcl_pkg::rsp_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [31:0]    cfg_data
);
  import pkcl_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  pkcl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  pkcl_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `PKCL_ASSERT_NEXT(a_lookup_not_ready, clk, rst, in_valid && in_ready, !in_ready)
  `PKCL_ASSERT_IMPLIES(a_invalid_clean, clk, rst,
    out_valid && (out_data.action == ACT_INVALID),
    (!out_data.limited) && (out_data.slot == 4'd0))
  `PKCL_ASSERT_IMPLIES(a_limited_code, clk, rst, out_valid,
    out_data.limited == (out_data.action == ACT_HIT_LIMITED))

endmodule

@@ rtl/pkcl_ctrl.sv @@
// Controller state machine of the cooldown limiter: capture, lookup, update.
module pkcl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  input  pkcl_pkg::dp_status_t status,
  output logic                in_ready,
  output pkcl_pkg::ctrl_cmd_t cmd
);
  import pkcl_pkg::*;

  state_t state;
  state_t state_next;
  logic   upd_ok;

  // The update may finish once the output register is free or is being emptied.
  assign upd_ok = !status.out_full || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (upd_ok) state_next = in_valid ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.lookup  = 1'b0;
    cmd.update  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      ST_UPDATE: begin
        in_ready   = upd_ok;
        cmd.update = upd_ok;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.capture = in_valid && in_ready;
  end

endmodule

@@ rtl/pkcl_datapath.sv @@
// Datapath of the cooldown limiter: key table, lookup, update and output register.
module pkcl_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pkcl_pkg::ctrl_cmd_t cmd,
  input  pkcl_pkg::req_t      in_data,
  input  logic                cfg_write,
  input  logic [31:0]         cfg_data,
  input  logic                out_ready,
  output pkcl_pkg::dp_status_t status,
  output logic                out_valid,
  output pkcl_pkg::rsp_t      out_data
);
  import pkcl_pkg::*;

  req_t        req;
  logic [31:0] cooldown;
  logic [63:0] keys [ENTRIES];
  logic [31:0] last_ms [ENTRIES];

  logic hit;
  idx_t hit_idx;
  logic free_any;
  idx_t free_idx;

  logic hit_next;
  idx_t hit_idx_next;
  logic free_any_next;
  idx_t free_idx_next;

  logic [31:0] elapsed;
  logic        wr_en;
  idx_t        wr_idx;
  rsp_t        rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown <= COOLDOWN_RESET;
    end else if (cfg_write) begin
      cooldown <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req <= in_data;
  end

  // Parallel key compare with priority pick of the lowest match and lowest free entry.
  always_comb begin
    hit_next      = 1'b0;
    hit_idx_next  = '0;
    free_any_next = 1'b0;
    free_idx_next = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (keys[i] == req.key) begin
        hit_next     = 1'b1;
        hit_idx_next = idx_t'(i);
      end
      if (keys[i] == 64'd0) begin
        free_any_next = 1'b1;
        free_idx_next = idx_t'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit      <= hit_next;
      hit_idx  <= hit_idx_next;
      free_any <= free_any_next;
      free_idx <= free_idx_next;
    end
  end

  assign elapsed = req.now_ms - last_ms[hit_idx];

  always_comb begin
    wr_en       = 1'b0;
    wr_idx      = hit_idx;
    rsp.limited = 1'b0;
    rsp.action  = ACT_HIT_OK;
    if (req.key == 64'd0) begin
      wr_idx     = '0;
      rsp.action = ACT_INVALID;
    end else if (hit) begin
      if (elapsed < cooldown) begin
        rsp.limited = 1'b1;
        rsp.action  = ACT_HIT_LIMITED;
      end else begin
        wr_en = 1'b1;
      end
    end else if (free_any) begin
      wr_en      = 1'b1;
      wr_idx     = free_idx;
      rsp.action = ACT_FILLED;
    end else begin
      wr_en      = 1'b1;
      wr_idx     = req.now_ms[IDX_W-1:0];
      rsp.action = ACT_EVICTED;
    end
    rsp.slot = 4'(wr_idx);
  end

  // Keys reset to zero so every entry starts free; stored times are read only on a hit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) keys[i] <= 64'd0;
    end else if (cmd.update && wr_en) begin
      keys[wr_idx] <= req.key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && wr_en) last_ms[wr_idx] <= req.now_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) out_data <= rsp;
  end

  assign status.out_full = out_valid;

endmodule
